@@ sv/wsrx_pkg.sv @@
// ----------------------------------------------------------------------------
// wsrx_pkg
// Shared types, codes and the UTF-8 step function for the WebSocket
// receive frame checker.
// ----------------------------------------------------------------------------
package wsrx_pkg;

   // result kinds
   localparam logic [2:0] KIND_TEXT_BYTE  = 3'd0;
   localparam logic [2:0] KIND_MSG_OK     = 3'd1;
   localparam logic [2:0] KIND_PONG_BYTE  = 3'd2;
   localparam logic [2:0] KIND_PONG_END   = 3'd3;
   localparam logic [2:0] KIND_CLOSE_BYTE = 3'd4;
   localparam logic [2:0] KIND_CLOSE_END  = 3'd5;
   localparam logic [2:0] KIND_CLOSE_CODE = 3'd6;

   // close status codes
   localparam logic [12:0] CODE_PROTOCOL = 13'd1002;
   localparam logic [12:0] CODE_DATATYPE = 13'd1003;
   localparam logic [12:0] CODE_BADDATA  = 13'd1007;
   localparam logic [12:0] CODE_TOOBIG   = 13'd1009;

   // opcodes
   localparam logic [3:0] OP_CONT  = 4'd0;
   localparam logic [3:0] OP_TEXT  = 4'd1;
   localparam logic [3:0] OP_BIN   = 4'd2;
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING  = 4'd9;
   localparam logic [3:0] OP_PONG  = 4'd10;

   // one result transaction
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [12:0] status;
      logic        last;
   } wsrx_result_type;

   // results produced by one accepted byte (0..2)
   typedef struct packed {
      logic [1:0]      count;
      wsrx_result_type r0;
      wsrx_result_type r1;
   } wsrx_push_type;

   typedef struct packed {
      logic [1:0]  rem;
      logic [20:0] cp;
      logic [1:0]  cls;
      logic        bad;
   } wsrx_utf8_type;

   // one UTF-8 decoder step; once bad the state freezes
   function automatic wsrx_utf8_type utf8_feed(wsrx_utf8_type s, logic [7:0] b);
      wsrx_utf8_type r;
      logic [20:0]   mn;
      r  = s;
      mn = 21'h80;
      if (!s.bad) begin
         if (s.rem != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               r.bad = 1'b1;
            end else begin
               r.cp  = {s.cp[14:0], b[5:0]};
               r.rem = s.rem - 2'd1;
               if (r.rem == 2'd0) begin
                  mn = (s.cls == 2'd0) ? 21'h80 : ((s.cls == 2'd1) ? 21'h800 : 21'h10000);
                  if (r.cp < mn || r.cp > 21'h10FFFF ||
                      (r.cp >= 21'hD800 && r.cp <= 21'hDFFF)) begin
                     r.bad = 1'b1;
                  end
               end
            end
         end else if (b >= 8'h80) begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
               r.cp = {16'd0, b[4:0]}; r.cls = 2'd0; r.rem = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               r.cp = {17'd0, b[3:0]}; r.cls = 2'd1; r.rem = 2'd2;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               r.cp = {18'd0, b[2:0]}; r.cls = 2'd2; r.rem = 2'd3;
            end else begin
               r.bad = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

@@ sv/wsrx_parser.sv @@
// ----------------------------------------------------------------------------
// wsrx_parser
// Frame parse state and per-byte logic: header, length, mask, payload
// unmasking, fragment and UTF-8 tracking, close checks.
// ----------------------------------------------------------------------------
module wsrx_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic [23:0]            max_len,
   output wsrx_pkg::wsrx_push_type push
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        final_ff, final_in;
   logic [63:0] len_ff, len_in;
   logic [3:0]  ebl_ff, ebl_in;
   logic [31:0] mask_ff, mask_in;
   logic [23:0] pidx_ff, pidx_in;
   logic [23:0] used_ff, used_in;
   logic        frag_ff, frag_in;
   wsrx_pkg::wsrx_utf8_type txt_ff, txt_in;
   logic [15:0] ccode_ff, ccode_in;
   wsrx_pkg::wsrx_utf8_type rsn_ff, rsn_in;
   logic        halted_ff, halted_in;

   // next-state and result logic
   always_comb begin
      logic [6:0]  len7;
      logic [24:0] sum;
      logic        go;
      logic        do_end;
      logic [7:0]  d;
      logic        e0_v, e1_v;
      wsrx_pkg::wsrx_result_type e0, e1;
      wsrx_pkg::wsrx_utf8_type   u;
      logic [15:0] c;
      logic        code_ok;

      phase_in  = phase_ff;  opcode_in = opcode_ff; final_in = final_ff;
      len_in    = len_ff;    ebl_in    = ebl_ff;    mask_in  = mask_ff;
      pidx_in   = pidx_ff;   used_in   = used_ff;   frag_in  = frag_ff;
      txt_in    = txt_ff;    ccode_in  = ccode_ff;  rsn_in   = rsn_ff;
      halted_in = halted_ff;
      len7 = rx_byte[6:0];
      sum  = {1'b0, used_ff} + {1'b0, len_ff[23:0]};
      go = 1'b0; do_end = 1'b0;
      d = rx_byte ^ mask_ff[8*(3-pidx_ff[1:0]) +: 8];
      e0_v = 1'b0; e1_v = 1'b0; e0 = '0; e1 = '0;
      u = '0; c = '0; code_ok = 1'b0;

      if (accept && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               len_in    = {56'd0, rx_byte};
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               if (len_ff[6:4] != 3'd0 || !rx_byte[7] ||
                   (opcode_ff >= 4'd3 && opcode_ff <= 4'd7) ||
                   opcode_ff > wsrx_pkg::OP_PONG ||
                   (opcode_ff >= wsrx_pkg::OP_CLOSE && (!final_ff || len7 > 7'd125))) begin
                  e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                  e1.status = wsrx_pkg::CODE_PROTOCOL; halted_in = 1'b1;
               end else if (len7 >= 7'd126) begin
                  len_in   = '0;
                  ebl_in   = (len7 == 7'd126) ? 4'd2 : 4'd8;
                  phase_in = (len7 == 7'd126) ? PH_EXT16 : PH_EXT64;
               end else begin
                  len_in = {57'd0, len7};
                  if ({17'd0, len7} > max_len) begin
                     e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                     e1.status = wsrx_pkg::CODE_TOOBIG; halted_in = 1'b1;
                  end else begin
                     ebl_in = 4'd4; mask_in = '0; phase_in = PH_MASK;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               len_in = {len_ff[55:0], rx_byte};
               ebl_in = ebl_ff - 4'd1;
               if (ebl_in == 4'd0) begin
                  if ((phase_ff == PH_EXT16 && len_in < 64'd126) ||
                      (phase_ff == PH_EXT64 && (len_in[63] || len_in < 64'd65536))) begin
                     e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                     e1.status = wsrx_pkg::CODE_PROTOCOL; halted_in = 1'b1;
                  end else if ((|len_in[63:24]) || len_in[23:0] > max_len) begin
                     e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                     e1.status = wsrx_pkg::CODE_TOOBIG; halted_in = 1'b1;
                  end else begin
                     ebl_in = 4'd4; mask_in = '0; phase_in = PH_MASK;
                  end
               end
            end
            PH_MASK: begin
               mask_in = {mask_ff[23:0], rx_byte};
               ebl_in  = ebl_ff - 4'd1;
               if (ebl_in == 4'd0) begin
                  // frame start checks
                  if (opcode_ff < wsrx_pkg::OP_CLOSE) begin
                     if (opcode_ff == wsrx_pkg::OP_BIN) begin
                        e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                        e1.status = wsrx_pkg::CODE_DATATYPE; halted_in = 1'b1;
                     end else if ((opcode_ff == wsrx_pkg::OP_CONT) != frag_ff) begin
                        e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                        e1.status = wsrx_pkg::CODE_PROTOCOL; halted_in = 1'b1;
                     end else if (sum > {1'b0, max_len}) begin
                        e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                        e1.status = wsrx_pkg::CODE_TOOBIG; halted_in = 1'b1;
                     end else begin
                        used_in = sum[23:0];
                        go = 1'b1;
                     end
                  end else begin
                     go = 1'b1;
                  end
                  if (go) begin
                     if (opcode_ff == wsrx_pkg::OP_CLOSE) begin
                        ccode_in = '0; rsn_in = '0;
                     end
                     pidx_in = '0;
                     if (len_ff == 64'd0) do_end = 1'b1;
                     else phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               e0_v = 1'b0;
               if (opcode_ff <= wsrx_pkg::OP_TEXT) begin
                  e0_v = 1'b1; e0.kind = wsrx_pkg::KIND_TEXT_BYTE; e0.data = d;
                  u = wsrx_pkg::utf8_feed(txt_ff, d);
                  if (d == 8'd0) u.bad = 1'b1;
                  txt_in = u;
               end else if (opcode_ff == wsrx_pkg::OP_PING) begin
                  e0_v = 1'b1; e0.kind = wsrx_pkg::KIND_PONG_BYTE; e0.data = d;
               end else if (opcode_ff == wsrx_pkg::OP_CLOSE) begin
                  e0_v = 1'b1; e0.kind = wsrx_pkg::KIND_CLOSE_BYTE; e0.data = d;
                  if (pidx_ff < 24'd2) begin
                     ccode_in = {ccode_ff[7:0], d};
                  end else begin
                     u = rsn_ff;
                     u.bad = (rsn_ff.cls == 2'd3);
                     u = wsrx_pkg::utf8_feed(u, d);
                     if (u.bad) u.cls = 2'd3;
                     u.bad = 1'b0;
                     rsn_in = u;
                  end
               end
               pidx_in = pidx_ff + 24'd1;
               if ({40'd0, pidx_in} >= len_ff) do_end = 1'b1;
            end
            default: phase_in = PH_HDR0;
         endcase

         // end of frame
         if (do_end) begin
            phase_in = PH_HDR0;
            if (opcode_ff <= wsrx_pkg::OP_TEXT) begin
               if (final_ff) begin
                  e1_v = 1'b1;
                  if (txt_in.bad || txt_in.rem != 2'd0) begin
                     e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
                     e1.status = wsrx_pkg::CODE_BADDATA; halted_in = 1'b1;
                  end else begin
                     e1.kind = wsrx_pkg::KIND_MSG_OK;
                  end
                  used_in = '0; txt_in = '0; frag_in = 1'b0;
               end else begin
                  frag_in = 1'b1;
               end
            end else if (opcode_ff == wsrx_pkg::OP_PING) begin
               e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_PONG_END;
            end else if (opcode_ff == wsrx_pkg::OP_CLOSE) begin
               c = ccode_in;
               code_ok = (c >= 16'd1000 && c <= 16'd1014 && c != 16'd1004 &&
                          c != 16'd1005 && c != 16'd1006) ||
                         (c >= 16'd3000 && c <= 16'd4999);
               e1_v = 1'b1; e1.kind = wsrx_pkg::KIND_CLOSE_CODE;
               if (len_ff == 64'd1 || (len_ff >= 64'd2 && !code_ok)) begin
                  e1.status = wsrx_pkg::CODE_PROTOCOL;
               end else if (len_ff >= 64'd2 &&
                            (rsn_in.cls == 2'd3 || rsn_in.rem != 2'd0)) begin
                  e1.status = wsrx_pkg::CODE_BADDATA;
               end else begin
                  e1.kind = wsrx_pkg::KIND_CLOSE_END;
               end
               halted_in = 1'b1;
            end
         end
      end

      // pack results, last marks the final one
      push = '0;
      if (e0_v && e1_v) begin
         push.count = 2'd2; push.r0 = e0; push.r1 = e1; push.r1.last = 1'b1;
      end else if (e0_v) begin
         push.count = 2'd1; push.r0 = e0; push.r0.last = 1'b1;
      end else if (e1_v) begin
         push.count = 2'd1; push.r0 = e1; push.r0.last = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0; final_ff <= 1'b0; len_ff <= '0; ebl_ff <= '0;
         mask_ff   <= '0; pidx_ff  <= '0;   used_ff <= '0; frag_ff <= 1'b0;
         txt_ff    <= '0; ccode_ff <= '0;   rsn_ff <= '0; halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in; final_ff <= final_in; len_ff <= len_in;
         ebl_ff    <= ebl_in;    mask_ff  <= mask_in;  pidx_ff <= pidx_in;
         used_ff   <= used_in;   frag_ff  <= frag_in;  txt_ff <= txt_in;
         ccode_ff  <= ccode_in;  rsn_ff   <= rsn_in;   halted_ff <= halted_in;
      end
   end

endmodule

@@ sv/wsrx_out_fifo.sv @@
// ----------------------------------------------------------------------------
// wsrx_out_fifo
// Four-entry result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module wsrx_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  wsrx_pkg::wsrx_push_type  push,
   output logic                     space2,
   output logic                     out_valid,
   input  logic                     out_ready,
   output wsrx_pkg::wsrx_result_type out_data
);

   wsrx_pkg::wsrx_result_type mem_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != 3'd0);
   assign out_data  = mem_ff[rd_ff];
   assign space2    = (cnt_ff <= 3'd2);

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff + push.count;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ff] <= push.r0;
      if (push.count == 2'd2) mem_ff[wr_ff + 2'd1] <= push.r1;
   end

endmodule

@@ sv/websocket_rx_frame_checker.sv @@
// ----------------------------------------------------------------------------
// websocket_rx_frame_checker
// Server-side WebSocket receive checker: parses, unmasks and validates the
// client byte stream and reports payload bytes and close codes.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle; each accepted byte updates the frame parser
// in the same cycle and pushes zero, one or two results into a four-entry
// output queue. req_ready stays high while the queue has room for two
// results, so with a consumer that keeps rsp_ready high the block sustains
// one byte per clock; the queue depth sets how long it rides out stalls.
// Results for a frame must be held downstream until its end marker (kinds
// 1, 3, 5); a kind 6 close code replaces them and halts the block until
// reset. max_message_length is written through csr_ and should change only
// while idle.
// ----------------------------------------------------------------------------
module websocket_rx_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [12:0] rsp_close_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_max_message_length
);

   logic [23:0]                max_len_ff;
   logic                       space2;
   wsrx_pkg::wsrx_push_type    push;
   wsrx_pkg::wsrx_result_type  head;

   assign csr_ready = 1'b1;
   assign req_ready = space2;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 24'd4096;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_message_length;
      end
   end

   wsrx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .rx_byte (req_rx_byte),
      .max_len (max_len_ff),
      .push    (push)
   );

   wsrx_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space2    (space2),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_data       = head.data;
   assign rsp_close_code = head.status;
   assign rsp_last       = head.last;

endmodule
